// ----- design/lhp_pkg.sv -----
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types, widths and constants for the latency histogram monitor.
// ----------------------------------------------------------------------------
package lhp_pkg;

	localparam int VAL_W       = 64;
	localparam int PCT_W       = 7;
	localparam int BIN_W       = 4;
	localparam int CNT_W       = 32;
	localparam int TOTAL_W     = 48;
	localparam int BIN_COUNT   = 16;
	localparam int LIMIT_COUNT = 15;
	localparam int CUM_W       = CNT_W + BIN_W;
	localparam int QUO_W       = 26;
	localparam int PROD_W      = CNT_W + QUO_W;
	localparam int RANK_W      = CNT_W + 1;
	localparam int RP_W        = 14;
	localparam int CEIL_PROD_W = 27;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
	// floor(2^32 / 100): quotient estimate that is low by at most one
	localparam logic [QUO_W-1:0]   RECIP_100 = 26'd42949672;
	// ceil(2^19 / 100): exact floor(x / 100) for x below 2^14
	localparam logic [12:0]        RECIP_CEIL = 13'd5243;

	typedef struct packed {
		logic               is_query;
		logic [VAL_W-1:0]   value;
		logic [PCT_W-1:0]   pct;
		logic [BIN_W-1:0]   bin;
	} entry_t;

	typedef struct packed {
		logic               is_query;
		logic [BIN_W-1:0]   bin_index;
		logic [VAL_W-1:0]   bound_us;
		logic [CNT_W-1:0]   sample_count;
		logic [TOTAL_W-1:0] total_us;
		logic [VAL_W-1:0]   max_us;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_RANK,
		ST_WALK,
		ST_DONE
	} back_state_t;

	function automatic logic [VAL_W-1:0] bin_limit(input logic [BIN_W-1:0] idx);
		logic [VAL_W-1:0] lim;
		case (idx)
			4'd0:    lim = 64'd100;
			4'd1:    lim = 64'd250;
			4'd2:    lim = 64'd500;
			4'd3:    lim = 64'd1000;
			4'd4:    lim = 64'd2000;
			4'd5:    lim = 64'd4000;
			4'd6:    lim = 64'd8000;
			4'd7:    lim = 64'd16000;
			4'd8:    lim = 64'd32000;
			4'd9:    lim = 64'd64000;
			4'd10:   lim = 64'd128000;
			4'd11:   lim = 64'd256000;
			4'd12:   lim = 64'd512000;
			4'd13:   lim = 64'd1000000;
			4'd14:   lim = 64'd2000000;
			default: lim = '1;
		endcase
		return lim;
	endfunction

endpackage

// ----- design/latency_histogram_percentile.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_percentile
// Latency histogram monitor with percentile queries over 16 fixed bins.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is req_type (0 record, 1 query), tdata holds
//   the duration and the percentile. m_axis returns one result per request.
//   Records are binned at the input, queued (two entries) and applied by the
//   execution unit; a record's result passes through the queue and the output
//   register to m_axis, and records sustain one per cycle while m_axis does
//   not stall and no query is in progress. A query computes its rank (divide
//   by 100 by reciprocal, correction, multiply, ceiling), walks the bin counters
//   one bin a cycle through a single counter read port and then loads the
//   output register once it is free. A query on an empty histogram is answered
//   straight from idle, without the rank and walk steps.
//   Reset clears all counters, the total and the maximum at once.
//   When m_axis stalls, the output register holds its result, the execution
//   unit waits, and the queue fills before s_axis_tready drops.
// ----------------------------------------------------------------------------
module latency_histogram_percentile import lhp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,  // value_us[63:0], percentile[70:64]
	input  logic         s_axis_tuser,  // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [215:0] m_axis_tdata,  // bin_index[3:0], bound_us[67:4],
	                                    // sample_count[99:68], total_us[147:100],
	                                    // max_us[211:148]
	output logic         m_axis_tuser   // is_query
);

	entry_t  push_entry;
	entry_t  head;
	logic    push;
	logic    pop;
	logic    empty;
	logic    full;
	logic    emit;
	logic    slot_free;
	result_t result;
	result_t out_q;
	logic    out_valid_q;

	lhp_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.queue_full    (full),
		.push          (push),
		.entry         (push_entry)
	);

	lhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	lhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.slot_free (slot_free),
		.pop       (pop),
		.emit      (emit),
		.result    (result)
	);

	assign slot_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.is_query;
	assign m_axis_tdata  = {4'b0, out_q.max_us, out_q.total_us, out_q.sample_count,
		out_q.bound_us, out_q.bin_index};

endmodule

// ----- design/lhp_front.sv -----
// ----------------------------------------------------------------------------
// lhp_front
// Accepts requests, picks the bin of a record and clamps the percentile.
// ----------------------------------------------------------------------------
module lhp_front import lhp_pkg::*; (
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [71:0]            s_axis_tdata,  // value_us[63:0], percentile[70:64]
	input  logic                   s_axis_tuser,  // req_type
	input  logic                   queue_full,
	output logic                   push,
	output entry_t                 entry
);

	logic [VAL_W-1:0] value;
	logic [PCT_W-1:0] pct_raw;
	logic [BIN_W-1:0] bin;

	assign value   = s_axis_tdata[VAL_W-1:0];
	assign pct_raw = s_axis_tdata[VAL_W+PCT_W-1:VAL_W];

	// first limit that holds the value wins; above all limits goes to the last bin
	always_comb begin
		bin = BIN_W'(BIN_COUNT - 1);
		for (int i = LIMIT_COUNT - 1; i >= 0; i--) begin
			if (value <= bin_limit(BIN_W'(i))) begin
				bin = BIN_W'(i);
			end
		end
	end

	assign s_axis_tready  = !queue_full;
	assign push           = s_axis_tvalid && !queue_full;
	assign entry.is_query = s_axis_tuser;
	assign entry.value    = value;
	assign entry.pct      = (pct_raw > PCT_MAX) ? PCT_MAX : pct_raw;
	assign entry.bin      = bin;

endmodule

// ----- design/lhp_queue.sv -----
// ----------------------------------------------------------------------------
// lhp_queue
// Two-entry queue between the classifier and the execution unit.
// ----------------------------------------------------------------------------
module lhp_queue import lhp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- design/lhp_back.sv -----
// ----------------------------------------------------------------------------
// lhp_back
// Execution unit: updates the histogram on records, walks the bins on queries.
// ----------------------------------------------------------------------------
module lhp_back import lhp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  entry_t  head,
	input  logic    empty,
	input  logic    slot_free,
	output logic    pop,
	output logic    emit,
	output result_t result
);

	back_state_t state_q, state_nxt;

	logic [CNT_W-1:0]   bin_cnt_q [BIN_COUNT];
	logic [CNT_W-1:0]   samples_q;
	logic [TOTAL_W-1:0] total_q;
	logic [VAL_W-1:0]   max_q;

	logic [PROD_W-1:0]  prod_q;
	logic [PCT_W-1:0]   pct_q;
	logic [QUO_W-1:0]   quo_q;
	logic [7:0]         rem_q;
	logic [RANK_W-1:0]  qp_q;
	logic [RP_W-1:0]    rp_q;
	logic [RANK_W-1:0]  rank_q;
	logic [CUM_W-1:0]   cum_q;
	logic [BIN_W-1:0]   walk_idx_q;
	logic [VAL_W-1:0]   bound_q;

	logic               rec_go;
	logic               qry_go;
	logic               qry_empty;
	logic [BIN_W-1:0]   rd_idx;
	logic [CNT_W-1:0]   rd_cnt;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   smp_inc;
	logic [VAL_W:0]     sum_wide;
	logic [TOTAL_W-1:0] total_nxt;
	logic [VAL_W-1:0]   max_nxt;
	logic [CUM_W-1:0]   cum_nxt;
	logic               hit;

	logic [QUO_W-1:0]   quo_est;
	logic [RANK_W-1:0]  rem_wide;
	logic               rem_over;
	logic [QUO_W-1:0]   quo_fix;
	logic [PCT_W-1:0]   rem_fix;
	logic [RP_W-1:0]    ceil_arg;
	logic [CEIL_PROD_W-1:0] ceil_prod;
	logic [RANK_W-1:0]  rank_raw;

	assign qry_empty = (samples_q == '0);
	assign rec_go    = (state_q == ST_IDLE) && !empty && slot_free && !head.is_query;
	assign qry_go    = (state_q == ST_IDLE) && !empty && slot_free && head.is_query;

	// one read port: the walk index while walking, else the record's bin
	assign rd_idx  = (state_q == ST_WALK) ? walk_idx_q : head.bin;
	assign rd_cnt  = bin_cnt_q[rd_idx];
	assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
	assign smp_inc = (samples_q == '1) ? samples_q : samples_q + 1'b1;

	assign sum_wide  = {{(VAL_W + 1 - TOTAL_W){1'b0}}, total_q} + {1'b0, head.value};
	assign total_nxt = (sum_wide >= {{(VAL_W + 1 - TOTAL_W){1'b0}}, TOTAL_MAX}) ?
		TOTAL_MAX : sum_wide[TOTAL_W-1:0];
	assign max_nxt   = (head.value > max_q) ? head.value : max_q;

	assign cum_nxt = cum_q + CUM_W'(rd_cnt);
	assign hit     = (cum_nxt >= CUM_W'(rank_q)) || (walk_idx_q == BIN_W'(BIN_COUNT - 1));

	// n / 100: estimate, remainder, one correction step
	assign quo_est   = prod_q[PROD_W-1:CNT_W];
	assign rem_wide  = {1'b0, samples_q} - RANK_W'(RANK_W'(quo_est) * RANK_W'(100));
	assign rem_over  = (rem_q >= 8'd100);
	assign quo_fix   = rem_over ? quo_q + 1'b1 : quo_q;
	assign rem_fix   = rem_over ? PCT_W'(rem_q - 8'd100) : PCT_W'(rem_q);
	assign ceil_arg  = rp_q + RP_W'(99);
	assign ceil_prod = CEIL_PROD_W'(ceil_arg) * CEIL_PROD_W'(RECIP_CEIL);
	assign rank_raw  = qp_q + RANK_W'(ceil_prod[CEIL_PROD_W-1:19]);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (qry_go && !qry_empty) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV:  state_nxt = ST_FIX;
			ST_FIX:  state_nxt = ST_RANK;
			ST_RANK: state_nxt = ST_WALK;
			ST_WALK: begin
				if (hit) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		pop  = rec_go || qry_go;
		emit = rec_go || (qry_go && qry_empty) || ((state_q == ST_DONE) && slot_free);
		if (rec_go) begin
			result.is_query     = 1'b0;
			result.bin_index    = head.bin;
			result.bound_us     = '0;
			result.sample_count = smp_inc;
			result.total_us     = total_nxt;
			result.max_us       = max_nxt;
		end else begin
			result.is_query     = 1'b1;
			result.bin_index    = '0;
			result.bound_us     = (state_q == ST_DONE) ? bound_q : '0;
			result.sample_count = samples_q;
			result.total_us     = total_q;
			result.max_us       = max_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			samples_q <= '0;
			total_q   <= '0;
			max_q     <= '0;
			for (int i = 0; i < BIN_COUNT; i++) begin
				bin_cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (rec_go) begin
				bin_cnt_q[head.bin] <= cnt_inc;
				samples_q           <= smp_inc;
				total_q             <= total_nxt;
				max_q               <= max_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qry_go) begin
			prod_q <= PROD_W'(samples_q) * PROD_W'(RECIP_100);
			pct_q  <= head.pct;
		end
		if (state_q == ST_DIV) begin
			quo_q <= quo_est;
			rem_q <= rem_wide[7:0];
		end
		if (state_q == ST_FIX) begin
			qp_q <= RANK_W'(quo_fix) * RANK_W'(pct_q);
			rp_q <= RP_W'(rem_fix) * RP_W'(pct_q);
		end
		if (state_q == ST_RANK) begin
			rank_q     <= (rank_raw == '0) ? RANK_W'(1) : rank_raw;
			cum_q      <= '0;
			walk_idx_q <= '0;
		end
		if (state_q == ST_WALK) begin
			cum_q <= cum_nxt;
			if (hit) begin
				bound_q <= (walk_idx_q == BIN_W'(LIMIT_COUNT)) ? max_q : bin_limit(walk_idx_q);
			end else begin
				walk_idx_q <= walk_idx_q + 1'b1;
			end
		end
	end

	// histogram state only moves on a record taken in idle
	a_stats_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> ($stable(samples_q) && $stable(max_q) && $stable(total_q)))
		else $error("histogram state changed during a query");

	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ((state_q == ST_IDLE) || (state_q == ST_DONE)))
		else $error("result emitted mid-computation");

	a_max_grows: assert property (@(posedge clk) disable iff (!arst_n)
		rec_go |=> ((max_q >= $past(max_q)) && (samples_q >= $past(samples_q))))
		else $error("record lowered max or sample count");

endmodule
